[rtl/utt_pkg.sv]
// package: payload types, surrogate and utf-8 constants, byte encoding helpers
`default_nettype none

package utt_pkg;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        final_unit;
    } t_in_item;

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       run_end;
    } t_out_item;

    // one queued job: first code point always present, optional second one
    typedef struct packed {
        logic [20:0] cp_a;
        logic        has_b;
        logic [15:0] cp_b;
    } t_job;

    typedef enum logic [1:0] {
        LEN_ONE,
        LEN_TWO,
        LEN_THREE,
        LEN_FOUR
    } t_len;

    localparam logic [15:0] HIGH_SURR_MIN  = 16'hD800;
    localparam logic [15:0] HIGH_SURR_MAX  = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_MIN   = 16'hDC00;
    localparam logic [15:0] LOW_SURR_MAX   = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE      = 21'h10000;
    localparam logic [20:0] TWO_BYTE_MIN   = 21'h00080;
    localparam logic [20:0] THREE_BYTE_MIN = 21'h00800;
    localparam logic [5:0]  HIGH_SURR_TAG  = 6'b110110;
    localparam logic [7:0]  LEAD_TWO       = 8'hC0;
    localparam logic [7:0]  LEAD_THREE     = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR      = 8'hF0;
    localparam logic [7:0]  CONT_BYTE      = 8'h80;

    function automatic t_len utt_len(input logic [20:0] cp);
        t_len len;
        if (cp < TWO_BYTE_MIN) begin
            len = LEN_ONE;
        end else if (cp < THREE_BYTE_MIN) begin
            len = LEN_TWO;
        end else if (cp < SUPP_BASE) begin
            len = LEN_THREE;
        end else begin
            len = LEN_FOUR;
        end
        return len;
    endfunction

    function automatic logic [7:0] utt_byte(input logic [20:0] cp, input t_len len,
                                            input logic [1:0] k);
        logic [7:0] b;
        b = 8'h00;
        case (len)
            LEN_ONE: begin
                b = {1'b0, cp[6:0]};
            end
            LEN_TWO: begin
                case (k)
                    2'd0:    b = LEAD_TWO | {3'b000, cp[10:6]};
                    default: b = CONT_BYTE | {2'b00, cp[5:0]};
                endcase
            end
            LEN_THREE: begin
                case (k)
                    2'd0:    b = LEAD_THREE | {4'b0000, cp[15:12]};
                    2'd1:    b = CONT_BYTE | {2'b00, cp[11:6]};
                    default: b = CONT_BYTE | {2'b00, cp[5:0]};
                endcase
            end
            default: begin
                case (k)
                    2'd0:    b = LEAD_FOUR | {5'b00000, cp[20:18]};
                    2'd1:    b = CONT_BYTE | {2'b00, cp[17:12]};
                    2'd2:    b = CONT_BYTE | {2'b00, cp[11:6]};
                    default: b = CONT_BYTE | {2'b00, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[rtl/utt_front.sv]
// front end: accepts code units, pairs surrogates, builds byte jobs
`default_nettype none

module utt_front
    import utt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_item i_data,
    input  wire logic     i_full,
    output logic          o_push,
    output t_job          o_job
);

    logic        r_held_valid;
    logic [9:0]  r_held_bits;
    logic        n_held_valid;
    logic [9:0]  n_held_bits;
    logic        accept;
    logic        is_high;
    logic        is_low;
    logic        hold_new;
    logic [15:0] cu;

    assign accept = i_valid && !i_full;
    assign cu     = i_data.code_unit;

    always_comb begin
        is_high      = cu inside {[HIGH_SURR_MIN:HIGH_SURR_MAX]};
        is_low       = cu inside {[LOW_SURR_MIN:LOW_SURR_MAX]};
        hold_new     = is_high && !i_data.final_unit;
        n_held_valid = r_held_valid;
        n_held_bits  = r_held_bits;
        o_push       = 1'b0;
        o_job.cp_a   = {5'b00000, cu};
        o_job.has_b  = 1'b0;
        o_job.cp_b   = cu;
        if (accept) begin
            if (r_held_valid && is_low) begin
                // surrogate pair
                o_push       = 1'b1;
                o_job.cp_a   = SUPP_BASE + {1'b0, r_held_bits, cu[9:0]};
                n_held_valid = 1'b0;
                n_held_bits  = '0;
            end else if (r_held_valid) begin
                // flush held surrogate, then the new unit unless it is held
                o_push       = 1'b1;
                o_job.cp_a   = {5'b00000, HIGH_SURR_TAG, r_held_bits};
                o_job.has_b  = !hold_new;
                n_held_valid = hold_new;
                n_held_bits  = hold_new ? cu[9:0] : 10'd0;
            end else begin
                o_push       = !hold_new;
                n_held_valid = hold_new;
                n_held_bits  = hold_new ? cu[9:0] : 10'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_bits  <= '0;
        end else begin
            r_held_valid <= n_held_valid;
            r_held_bits  <= n_held_bits;
        end
    end

endmodule

`default_nettype wire

[rtl/utt_queue.sv]
// job queue between front end and byte serializer
`default_nettype none

module utt_queue
    import utt_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_job      o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

[rtl/utt_back.sv]
// back end: walks queued jobs and sends one utf-8 byte per transaction
`default_nettype none

module utt_back
    import utt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_job i_q_head,
    output logic      o_q_pop,
    output logic      o_valid,
    output t_out_item o_data,
    input  wire logic i_stall
);

    logic        r_part;
    logic [1:0]  r_idx;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [20:0] cur_cp;
    t_len        cur_len;
    logic [1:0]  cur_len_bits;
    logic        last_in_part;
    logic        load;
    t_out_item   n_out;

    assign cur_cp       = r_part ? {5'b00000, i_q_head.cp_b} : i_q_head.cp_a;
    assign cur_len      = utt_len(cur_cp);
    assign cur_len_bits = cur_len;
    assign last_in_part = (r_idx == cur_len_bits);
    assign load         = i_q_valid && (!r_out_valid || !i_stall);
    assign o_q_pop      = load && last_in_part && (r_part || !i_q_head.has_b);

    assign n_out.utf8_byte = utt_byte(cur_cp, cur_len, r_idx);
    assign n_out.run_end   = last_in_part && (r_part || !i_q_head.has_b);

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
                if (!last_in_part) begin
                    r_idx <= r_idx + 2'd1;
                end else begin
                    r_idx  <= '0;
                    r_part <= !r_part && i_q_head.has_b;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_part_has_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_part |-> i_q_valid && i_q_head.has_b)
        else $error("second code point selected without one queued");
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> r_idx <= cur_len_bits)
        else $error("byte index past sequence length");
    a_pop_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> o_valid && o_data.run_end)
        else $error("job retired without run end byte");
`endif

endmodule

`default_nettype wire

[rtl/utf16_to_utf8_transcoder_unit.sv]
// top level: utf-16 code units in, utf-8 bytes out
//
// channel  direction  valid    stall    payload
// input    in         i_valid  o_stall  i_data (code_unit, final_unit)
// output   out        o_valid  i_stall  o_data (utf8_byte, run_end)
//
// one output byte per cycle while a job waits and i_stall is low; a unit makes 1-3
// bytes, a surrogate pair 4, a flushed surrogate plus a following unit up to 6
// a unit is accepted every cycle while the job queue has room; the output
// byte serializer sets the sustained rate
// with an empty queue the job is queued, then its first byte is put in r_out
// reset clears the held surrogate, the job queue and the output register
// o_stall is high exactly while the job queue is full
`default_nettype none

module utf16_to_utf8_transcoder_unit
    import utt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_item i_data,
    output logic          o_stall,
    output logic          o_valid,
    output t_out_item     o_data,
    input  wire logic     i_stall
);

    logic push;
    t_job job;
    logic q_full;
    logic q_valid;
    t_job q_head;
    logic q_pop;

    assign o_stall = q_full;

    utt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_full  (q_full),
        .o_push  (push),
        .o_job   (job)
    );

    utt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    utt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

endmodule

`default_nettype wire

[test/tb_top.sv]
// testbench: utf-16 to utf-8 transcoder, directed table then random surrogate-heavy streams
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import utt_pkg::*;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        final_unit;
        logic        fixed;
        logic [2:0]  count;
        logic [47:0] bytes;
    } t_directed_unit;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    t_in_item  in_data;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      out_stall;

    t_out_item  pending_utf8[$];
    logic [7:0] unit_bytes[$];
    logic       held_valid;
    logic [9:0] held_bits;
    int         mismatches;
    int         send_idle_pct;
    int         recv_idle_pct;

    t_directed_unit directed_units [0:21] = '{
        '{16'h0000, 1'b0, 1'b1, 3'd1, 48'h00_00_00_00_00_00},
        '{16'h007F, 1'b0, 1'b1, 3'd1, 48'h7F_00_00_00_00_00},
        '{16'h0080, 1'b0, 1'b1, 3'd2, 48'hC2_80_00_00_00_00},
        '{16'h07FF, 1'b0, 1'b1, 3'd2, 48'hDF_BF_00_00_00_00},
        '{16'h0800, 1'b0, 1'b1, 3'd3, 48'hE0_A0_80_00_00_00},
        '{16'hFFFF, 1'b0, 1'b1, 3'd3, 48'hEF_BF_BF_00_00_00},
        '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00},
        '{16'hDC00, 1'b0, 1'b1, 3'd4, 48'hF0_90_80_80_00_00},
        '{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00},
        '{16'hDFFF, 1'b1, 1'b1, 3'd4, 48'hF4_8F_BF_BF_00_00},
        '{16'hDC00, 1'b0, 1'b1, 3'd3, 48'hED_B0_80_00_00_00},
        '{16'hDBFF, 1'b1, 1'b1, 3'd3, 48'hED_AF_BF_00_00_00},
        '{16'hD800, 1'b0, 1'b0, 3'd0, 48'h0},
        '{16'h0041, 1'b0, 1'b0, 3'd0, 48'h0},
        '{16'hDA12, 1'b0, 1'b0, 3'd0, 48'h0},
        '{16'hD999, 1'b0, 1'b0, 3'd0, 48'h0},
        '{16'h1234, 1'b1, 1'b0, 3'd0, 48'h0},
        '{16'hDFFF, 1'b1, 1'b1, 3'd3, 48'hED_BF_BF_00_00_00},
        '{16'hD800, 1'b0, 1'b0, 3'd0, 48'h0},
        '{16'hFFFF, 1'b0, 1'b0, 3'd0, 48'h0},
        '{16'h5555, 1'b1, 1'b0, 3'd0, 48'h0},
        '{16'hAAAA, 1'b0, 1'b0, 3'd0, 48'h0}
    };

    utf16_to_utf8_transcoder_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .i_data  (in_data),
        .o_stall (in_stall),
        .o_valid (out_valid),
        .o_data  (out_data),
        .i_stall (out_stall)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic put_code_point(input logic [20:0] cp);
        if (cp < 21'h00080) begin
            unit_bytes.push_back({1'b0, cp[6:0]});
        end else if (cp < 21'h00800) begin
            unit_bytes.push_back(8'hC0 | {3'b000, cp[10:6]});
            unit_bytes.push_back(8'h80 | {2'b00, cp[5:0]});
        end else if (cp < 21'h10000) begin
            unit_bytes.push_back(8'hE0 | {4'b0000, cp[15:12]});
            unit_bytes.push_back(8'h80 | {2'b00, cp[11:6]});
            unit_bytes.push_back(8'h80 | {2'b00, cp[5:0]});
        end else begin
            unit_bytes.push_back(8'hF0 | {5'b00000, cp[20:18]});
            unit_bytes.push_back(8'h80 | {2'b00, cp[17:12]});
            unit_bytes.push_back(8'h80 | {2'b00, cp[11:6]});
            unit_bytes.push_back(8'h80 | {2'b00, cp[5:0]});
        end
    endtask

    task automatic transcode_unit(input t_in_item u);
        logic is_high;
        logic is_low;
        is_high = (u.code_unit >= HIGH_SURR_MIN) && (u.code_unit <= HIGH_SURR_MAX);
        is_low  = (u.code_unit >= LOW_SURR_MIN) && (u.code_unit <= LOW_SURR_MAX);
        unit_bytes.delete();
        if (held_valid && is_low) begin
            put_code_point(21'h10000 + {1'b0, held_bits, u.code_unit[9:0]});
            held_valid = 1'b0;
            held_bits  = 10'd0;
        end else begin
            if (held_valid) begin
                put_code_point({5'b00000, 6'b110110, held_bits});
                held_valid = 1'b0;
                held_bits  = 10'd0;
            end
            if (is_high && !u.final_unit) begin
                held_valid = 1'b1;
                held_bits  = u.code_unit[9:0];
            end else begin
                put_code_point({5'b00000, u.code_unit});
            end
        end
    endtask

    task automatic queue_unit_bytes();
        t_out_item b;
        for (int k = 0; k < unit_bytes.size(); k++) begin
            b.utf8_byte = unit_bytes[k];
            b.run_end   = (k == unit_bytes.size() - 1);
            pending_utf8.push_back(b);
        end
    endtask

    task automatic drive_unit(input t_in_item u);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= u;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_unit(input logic [15:0] cu, input logic fin);
        t_in_item u;
        u.code_unit  = cu;
        u.final_unit = fin;
        transcode_unit(u);
        queue_unit_bytes();
        drive_unit(u);
    endtask

    task automatic send_random_stream(input int n);
        logic [15:0] cu;
        logic        fin;
        logic        want_low;
        int          pick;
        want_low = 1'b0;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (want_low && $urandom_range(99) < 80) begin
                cu = 16'($urandom_range(16'hDFFF, 16'hDC00));
            end else if (pick < 25) begin
                cu = 16'($urandom_range(16'h007F, 16'h0000));
            end else if (pick < 40) begin
                cu = 16'($urandom_range(16'h07FF, 16'h0080));
            end else if (pick < 55) begin
                cu = 16'($urandom_range(16'hD7FF, 16'h0800));
            end else if (pick < 65) begin
                cu = 16'($urandom_range(16'hFFFF, 16'hE000));
            end else if (pick < 85) begin
                cu = 16'($urandom_range(16'hDBFF, 16'hD800));
            end else if (pick < 95) begin
                cu = 16'($urandom_range(16'hDFFF, 16'hDC00));
            end else begin
                cu = 16'($urandom());
            end
            fin = ($urandom_range(9) == 0);
            want_low = (cu >= HIGH_SURR_MIN) && (cu <= HIGH_SURR_MAX) && !fin;
            send_unit(cu, fin);
        end
    endtask

    always @(posedge clk) begin : utf8_monitor
        t_out_item want;
        out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
        if (rst_n && out_valid && !out_stall) begin
            if (pending_utf8.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected byte %02h run_end %0b",
                             out_data.utf8_byte, out_data.run_end);
                end
            end else begin
                want = pending_utf8.pop_front();
                if (out_data.utf8_byte !== want.utf8_byte
                        || out_data.run_end !== want.run_end) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("byte mismatch: expected %02h/%0b, got %02h/%0b",
                                 want.utf8_byte, want.run_end,
                                 out_data.utf8_byte, out_data.run_end);
                    end
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin : stimulus
        t_in_item u;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_stall     = 1'b0;
        held_valid    = 1'b0;
        held_bits     = 10'd0;
        mismatches    = 0;
        send_idle_pct = 7;
        recv_idle_pct = 7;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_units[r]) begin
            u.code_unit  = directed_units[r].code_unit;
            u.final_unit = directed_units[r].final_unit;
            transcode_unit(u);
            if (directed_units[r].fixed) begin
                unit_bytes.delete();
                for (int k = 0; k < directed_units[r].count; k++) begin
                    unit_bytes.push_back(directed_units[r].bytes[47 - 8 * k -: 8]);
                end
            end
            queue_unit_bytes();
            drive_unit(u);
        end

        send_random_stream(150);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_stream(110);
        send_idle_pct = 7;
        recv_idle_pct = 7;
        send_random_stream(150);
        send_unit(16'h0041, 1'b1);
        in_valid <= 1'b0;

        while (pending_utf8.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

[utf16_to_utf8_transcoder_unit.f]
rtl/utt_pkg.sv
rtl/utt_front.sv
rtl/utt_queue.sv
rtl/utt_back.sv
rtl/utf16_to_utf8_transcoder_unit.sv
test/tb_top.sv
